// File: design/u32u16_pkg.sv
// ----------------------------------------------------------------------------
// u32u16_pkg
// shared types and constants of the utf-32 to utf-16 converter
// ----------------------------------------------------------------------------
package u32u16_pkg;

    // stream position counter width
    localparam int POSITION_WIDTH = 32;

    // descriptor queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BYTE_SWAP  = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ERROR_MODE = CFG_INDEX_WIDTH'(1);

    // error modes
    localparam logic [1:0] MODE_PRECISE = 2'd0;
    localparam logic [1:0] MODE_AT_END  = 2'd1;

    // result status codes
    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_SUCCESS   = 2'd1;
    localparam logic [1:0] ST_SURROGATE = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // code point constants
    localparam logic [31:0] CP_MAX        = 32'h0010_FFFF;
    localparam logic [31:0] CP_PLANE_MASK = 32'hFFFF_0000;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h1_0000;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SURR_PREFIX   = 21'h1B; // 0xD800..0xDFFF >> 11

    // one classified item: up to two results, the first only for a pair
    typedef struct packed {
        logic        pair;
        logic [15:0] unit_hi;
        logic [15:0] unit_fin;
        logic        fin_valid;
        logic [1:0]  fin_status;
        logic [31:0] fin_pos;
    } t_desc;

    localparam int DESC_WIDTH = $bits(t_desc);

    function automatic logic [15:0] swap_unit(input logic [15:0] u, input logic swap);
        swap_unit = swap ? {u[7:0], u[15:8]} : u;
    endfunction

endpackage

// File: design/u32u16_front.sv
// ----------------------------------------------------------------------------
// u32u16_front
// accepts code points, tracks stream state and builds result descriptors
// ----------------------------------------------------------------------------
module u32u16_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [u32u16_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [u32u16_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                   i_push,
    input  logic [31:0]                            i_code_point,
    input  logic                                   i_last_in,
    input  logic                                   i_q_full,
    output logic                                   o_q_write,
    output u32u16_pkg::t_desc                      o_q_data
);

    logic                                  r_byte_swap;
    logic [1:0]                            r_error_mode;
    logic [u32u16_pkg::POSITION_WIDTH-1:0] r_position;
    logic [u32u16_pkg::POSITION_WIDTH-1:0] n_position;
    logic                                  r_stopped;
    logic                                  n_stopped;
    logic                                  r_surr_seen;
    logic                                  n_surr_seen;

    logic        w_accept;
    logic        w_too_large;
    logic        w_is_surr;
    logic        w_error;
    logic        w_bmp;
    logic        w_new_surr;
    logic [20:0] w_v;
    logic [63:0] w_pos_ext;
    logic [31:0] w_pos;
    logic [1:0]  w_end_status;

    assign w_accept     = i_push && !i_q_full;
    assign w_too_large  = i_code_point > u32u16_pkg::CP_MAX;
    assign w_is_surr    = i_code_point[31:11] == u32u16_pkg::SURR_PREFIX;
    assign w_error      = w_too_large
                       || (w_is_surr && r_error_mode == u32u16_pkg::MODE_PRECISE);
    assign w_bmp        = (i_code_point & u32u16_pkg::CP_PLANE_MASK) == 32'd0;
    assign w_new_surr   = w_is_surr && r_error_mode == u32u16_pkg::MODE_AT_END;
    assign w_v          = i_code_point[20:0] - u32u16_pkg::CP_SUPP_BASE;
    assign w_pos_ext    = 64'(r_position);
    assign w_pos        = w_pos_ext[31:0];
    assign w_end_status = (r_surr_seen || (w_bmp && w_new_surr))
                        ? u32u16_pkg::ST_SURROGATE : u32u16_pkg::ST_SUCCESS;

    assign o_q_write = w_accept && !r_stopped;

    // descriptor build
    always_comb begin
        o_q_data = '0;
        if (w_error) begin
            o_q_data.fin_status = w_too_large ? u32u16_pkg::ST_TOO_LARGE
                                              : u32u16_pkg::ST_SURROGATE;
            o_q_data.fin_pos    = w_pos;
        end else begin
            o_q_data.fin_valid  = 1'b1;
            o_q_data.fin_status = i_last_in ? w_end_status : u32u16_pkg::ST_RUNNING;
            o_q_data.fin_pos    = i_last_in ? w_pos : 32'd0;
            if (w_bmp) begin
                o_q_data.unit_fin = u32u16_pkg::swap_unit(i_code_point[15:0], r_byte_swap);
            end else begin
                o_q_data.pair     = 1'b1;
                o_q_data.unit_hi  = u32u16_pkg::swap_unit(
                    u32u16_pkg::HI_SURR_BASE + {6'd0, w_v[19:10]}, r_byte_swap);
                o_q_data.unit_fin = u32u16_pkg::swap_unit(
                    u32u16_pkg::LO_SURR_BASE | {6'd0, w_v[9:0]}, r_byte_swap);
            end
        end
    end

    // stream state update
    always_comb begin
        n_position  = r_position;
        n_stopped   = r_stopped;
        n_surr_seen = r_surr_seen;
        if (w_accept) begin
            if (i_last_in) begin
                n_position  = '0;
                n_stopped   = 1'b0;
                n_surr_seen = 1'b0;
            end else if (!r_stopped) begin
                if (w_error) begin
                    n_stopped = 1'b1;
                end else begin
                    n_position = r_position + 1'b1;
                    if (w_bmp && w_new_surr) begin
                        n_surr_seen = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_swap  <= 1'b0;
            r_error_mode <= u32u16_pkg::MODE_PRECISE;
            r_position   <= '0;
            r_stopped    <= 1'b0;
            r_surr_seen  <= 1'b0;
        end else begin
            r_position  <= n_position;
            r_stopped   <= n_stopped;
            r_surr_seen <= n_surr_seen;
            if (i_cfg_valid && i_cfg_index == u32u16_pkg::CFG_BYTE_SWAP) begin
                r_byte_swap <= i_cfg_data[0];
            end
            if (i_cfg_valid && i_cfg_index == u32u16_pkg::CFG_ERROR_MODE) begin
                r_error_mode <= i_cfg_data[1:0];
            end
        end
    end

`ifndef SYNTHESIS
    // an error in mid stream stops it
    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_write && w_error && !i_last_in) |=> r_stopped)
        else $error("error in mid stream did not stop it");
`endif

endmodule

// File: design/u32u16_fifo.sv
// ----------------------------------------------------------------------------
// u32u16_fifo
// short descriptor queue that decouples the front from the back
// ----------------------------------------------------------------------------
module u32u16_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  u32u16_pkg::t_desc i_wr_data,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_rd_valid,
    output u32u16_pkg::t_desc o_rd_data
);

    u32u16_pkg::t_desc                   r_mem [u32u16_pkg::FIFO_DEPTH];
    logic [u32u16_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [u32u16_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [u32u16_pkg::FIFO_CNT_W-1:0]   r_count;

    function automatic logic [u32u16_pkg::FIFO_CNT_W-1:0] FIFO_CNT_W_ONE(input logic b);
        FIFO_CNT_W_ONE = u32u16_pkg::FIFO_CNT_W'(b);
    endfunction

    assign o_full     = r_count == u32u16_pkg::FIFO_CNT_W'(u32u16_pkg::FIFO_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W_ONE(i_wr) - FIFO_CNT_W_ONE(i_rd);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && !o_rd_valid))
        else $error("descriptor queue underflow");
`endif

endmodule

// File: design/u32u16_back.sv
// ----------------------------------------------------------------------------
// u32u16_back
// output register: sends one or two results per descriptor
// ----------------------------------------------------------------------------
module u32u16_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  u32u16_pkg::t_desc i_q_data,
    output logic              o_q_read,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [15:0]       o_unit,
    output logic              o_unit_valid,
    output logic              o_last_out,
    output logic [1:0]        o_status,
    output logic [31:0]       o_error_position
);

    u32u16_pkg::t_desc r_cur;
    logic              r_valid;
    logic              r_half;
    logic              w_taken;
    logic              w_free;

    assign w_taken  = i_pop && r_valid;
    assign w_free   = !r_valid || (w_taken && !r_half);
    assign o_q_read = w_free && i_q_valid;

    assign o_empty          = !r_valid;
    assign o_unit           = r_half ? r_cur.unit_hi : r_cur.unit_fin;
    assign o_unit_valid     = r_half || r_cur.fin_valid;
    assign o_last_out       = !r_half;
    assign o_status         = r_half ? u32u16_pkg::ST_RUNNING : r_cur.fin_status;
    assign o_error_position = r_half ? 32'd0 : r_cur.fin_pos;

    always_ff @(posedge i_clk) begin
        if (o_q_read) begin
            r_cur <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (o_q_read) begin
            r_valid <= 1'b1;
            r_half  <= i_q_data.pair;
        end else if (w_taken) begin
            if (r_half) begin
                r_half <= 1'b0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_half_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_valid)
        else $error("pair half pending without a held result");

    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_taken && r_half) |=> (r_valid && !r_half))
        else $error("low surrogate lost after high surrogate");
`endif

endmodule

// File: design/utf32_to_utf16_converter_top.sv
// ----------------------------------------------------------------------------
// utf32_to_utf16_converter_top
// utf-32 code points in, utf-16 units with stream status out
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  input    | i_push / o_full            | i_code_point, i_last_in
//  result   | o_empty / i_pop            | o_unit, o_unit_valid, o_last_out,
//           |                            | o_status, o_error_position
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one code point is taken per cycle while the queue has space; a supplementary
//  code point yields two results, high surrogate first, and the result side
//  takes no new descriptor until both are popped; the four-entry descriptor
//  queue absorbs bursts; the first result reaches the ports through the queue
//  write, then the output register load; it may be popped while o_empty is low
//  reset is synchronous and clears stream state, config and queue; no clearing pass
//  either side may stall independently; o_full only reflects queue space
// ----------------------------------------------------------------------------
module utf32_to_utf16_converter_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [u32u16_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [u32u16_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    // code point requests
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [31:0]                            i_code_point,
    input  logic                                   i_last_in,
    // results
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic [15:0]                            o_unit,
    output logic                                   o_unit_valid,
    output logic                                   o_last_out,
    output logic [1:0]                             o_status,
    output logic [31:0]                            o_error_position
);

    logic              w_q_write;
    u32u16_pkg::t_desc w_q_wdata;
    logic              w_q_full;
    logic              w_q_read;
    logic              w_q_valid;
    u32u16_pkg::t_desc w_q_rdata;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q_full;

    // front: classify, byte swap, position and error tracking
    u32u16_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .i_code_point (i_code_point),
        .i_last_in    (i_last_in),
        .i_q_full     (w_q_full),
        .o_q_write    (w_q_write),
        .o_q_data     (w_q_wdata)
    );

    // decoupling queue
    u32u16_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_q_write),
        .i_wr_data  (w_q_wdata),
        .o_full     (w_q_full),
        .i_rd       (w_q_read),
        .o_rd_valid (w_q_valid),
        .o_rd_data  (w_q_rdata)
    );

    // back: expand descriptors into one or two results
    u32u16_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_data         (w_q_rdata),
        .o_q_read         (w_q_read),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_unit           (o_unit),
        .o_unit_valid     (o_unit_valid),
        .o_last_out       (o_last_out),
        .o_status         (o_status),
        .o_error_position (o_error_position)
    );

endmodule
